### hw/rtl/piecewise_linear_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Piecewise linear interpolator assertion macros
// Shared assertion forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Condition holds in the same cycle as the antecedent
`define PLI_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Condition holds in the cycle after the antecedent
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Field widths, request codes, saturation limits and sequencer states.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int DATA_W     = 32;
    localparam int INDEX_W    = 10;
    localparam int CFG_W      = 11;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_W-1:0] POINTS_RESET = 11'd2;

    localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;
    localparam logic [DATA_W-1:0]  SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_CHECK,
        S_CMP,
        S_MUL,
        S_DIV,
        S_SUM,
        S_DONE
    } pli_state_t;

endpackage

### hw/rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Load request: written to the table in the cycle it is accepted, no result.
// Query outside the table or equal to the first x: settled in S_CHECK, no scan.
// Other query: the segment is found by a linear scan of the breakpoint RAM
// (one read per cycle), then S_MUL, a 32-step divider and S_SUM.
// One query at a time; s_tready is low until its result is registered.
// Reset clears control and sets points_in_use to 2; table undefined until loaded.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: points_in_use
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [9:0] point_index, [41:10] point_x, [73:42] point_f, [105:74] query_x
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                 s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] interp_value
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] out_of_range
    output logic                 m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);

    pli_state_t state_reg, state_next;

    logic [CFG_W-1:0]         points_reg;
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] f0_reg, f0_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [DATA_W-1:0]        den_reg, den_next;
    logic [DATA_W-1:0]        dq_reg, dq_next;
    logic [DATA_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [DATA_W-1:0]        lo_reg, lo_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [DATA_W-1:0]        res_reg, res_next;
    logic                     oor_reg, oor_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]        m_data_reg, m_data_next;
    logic                     m_oor_reg, m_oor_next;

    logic                     s_accept;
    logic [INDEX_W-1:0]       in_index;
    logic [DATA_W-1:0]        in_px;
    logic [DATA_W-1:0]        in_pf;
    logic [DATA_W-1:0]        in_qx;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [2*DATA_W-1:0]      ram_rdata;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_f;
    logic [16:0]              pts_ext;
    logic [AW-1:0]            last_idx;
    logic signed [DATA_W:0]   df;
    logic [DATA_W:0]          df_abs;
    logic [2*DATA_W-1:0]      prod;
    logic [DATA_W:0]          div_t;
    logic [DATA_W:0]          div_d;
    logic                     div_ge;
    logic signed [33:0]       sum;
    logic                     out_free;

    assign in_index = s_tdata[9:0];
    assign in_px    = s_tdata[41:10];
    assign in_pf    = s_tdata[73:42];
    assign in_qx    = s_tdata[105:74];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_oor_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // clamp the point count to 2..TABLE_DEPTH
    assign pts_ext = 17'(points_reg);
    always_comb begin
        if (pts_ext < 17'd2) begin
            last_idx = AW'(1);
        end else if (pts_ext > 17'(TABLE_DEPTH)) begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end else begin
            last_idx = AW'(pts_ext - 17'd1);
        end
    end

    assign ram_we    = s_accept && (s_tuser == MODE_LOAD)
                       && (32'(in_index) < 32'(TABLE_DEPTH));
    assign ram_waddr = AW'(in_index);

    pli_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data ({in_pf, in_px}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_x = $signed(ram_rdata[DATA_W-1:0]);
    assign rd_f = $signed(ram_rdata[2*DATA_W-1:DATA_W]);

    assign df     = {rd_f[DATA_W-1], rd_f} - {f0_reg[DATA_W-1], f0_reg};
    assign df_abs = df[DATA_W] ? (DATA_W+1)'(-df) : df;
    assign prod   = {32'b0, mag_reg} * {32'b0, dq_reg};
    assign div_t  = {rem_reg, lo_reg[DATA_W-1]};
    assign div_d  = div_t - {1'b0, den_reg};
    assign div_ge = (div_t >= {1'b0, den_reg});
    assign sum    = neg_reg ? ({{2{f0_reg[DATA_W-1]}}, f0_reg} - {2'b00, lo_reg})
                            : ({{2{f0_reg[DATA_W-1]}}, f0_reg} + {2'b00, lo_reg});

    always_comb begin
        state_next    = state_reg;
        q_next        = q_reg;
        x0_next       = x0_reg;
        f0_next       = f0_reg;
        idx_next      = idx_reg;
        den_next      = den_reg;
        dq_next       = dq_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        rem_next      = rem_reg;
        lo_next       = lo_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        oor_next      = oor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_oor_next    = m_oor_reg;
        ram_raddr     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_tuser == MODE_QUERY)) begin
                    q_next     = $signed(in_qx);
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                x0_next    = rd_x;
                f0_next    = rd_f;
                ram_raddr  = last_idx;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                ram_raddr = AW'(1);
                if ((q_reg < x0_reg) || (q_reg > rd_x)) begin
                    res_next   = '0;
                    oor_next   = 1'b1;
                    state_next = S_DONE;
                end else if (q_reg == x0_reg) begin
                    res_next   = f0_reg;
                    oor_next   = 1'b0;
                    state_next = S_DONE;
                end else begin
                    idx_next   = AW'(1);
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ram_raddr = idx_reg + AW'(1);
                if ((q_reg <= rd_x) || (idx_reg == last_idx)) begin
                    den_next   = rd_x - x0_reg;
                    dq_next    = q_reg - x0_reg;
                    neg_next   = df[DATA_W];
                    mag_next   = df_abs[DATA_W-1:0];
                    state_next = S_MUL;
                end else begin
                    x0_next  = rd_x;
                    f0_next  = rd_f;
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_MUL: begin
                rem_next   = prod[2*DATA_W-1:DATA_W];
                lo_next    = prod[DATA_W-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = div_ge ? div_d[DATA_W-1:0] : div_t[DATA_W-1:0];
                lo_next  = {lo_reg[DATA_W-2:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (sum > SUM_MAX) begin
                    res_next = SAT_MAX;
                end else if (sum < SUM_MIN) begin
                    res_next = SAT_MIN;
                end else begin
                    res_next = sum[DATA_W-1:0];
                end
                oor_next   = 1'b0;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    m_oor_next    = oor_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            points_reg   <= POINTS_RESET;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                points_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg      <= q_next;
        x0_reg     <= x0_next;
        f0_reg     <= f0_next;
        idx_reg    <= idx_next;
        den_reg    <= den_next;
        dq_reg     <= dq_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        res_reg    <= res_next;
        oor_reg    <= oor_next;
        m_data_reg <= m_data_next;
        m_oor_reg  <= m_oor_next;
    end

    `PLI_ASSERT_IMPLIES(a_div_den_nonzero, state_reg == S_DIV, den_reg != '0,
        "divide started with a zero segment width")
    `PLI_ASSERT_IMPLIES(a_div_rem_bound, state_reg == S_DIV, rem_reg < den_reg,
        "partial remainder not below the divisor")
    `PLI_ASSERT_IMPLIES(a_scan_bound, state_reg == S_CMP,
        idx_reg <= last_idx && idx_reg != '0, "scan index outside the active table")
    `PLI_ASSERT_IMPLIES(a_oor_zero, m_tvalid_reg && m_oor_reg, m_data_reg == '0,
        "out-of-range result carries a nonzero value")
    `PLI_ASSERT_NEXT(a_busy_after_query, s_accept && s_tuser == MODE_QUERY, !s_tready,
        "request accepted while a query is in progress")

endmodule

### hw/rtl/pli_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### tb/piecewise_linear_interpolator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator checker
// Watches the configuration, request and result channels, keeps its own copy
// of the breakpoint table and the point count, works out the value of every
// accepted query and compares each result against the oldest one outstanding.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_checker
    import pli_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [9:0] point_index, [41:10] point_x, [73:42] point_f, [105:74] query_x
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] interp_value
    input  logic [M_TDATA_W-1:0] m_tdata,
    // [0] out_of_range
    input  logic                 m_tuser,
    output int                   mismatches,
    output int                   pending_results
);

    localparam int PX_LSB = INDEX_W;
    localparam int PF_LSB = INDEX_W + DATA_W;
    localparam int QX_LSB = INDEX_W + 2 * DATA_W;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              out_of_range;
    } interp_result_t;

    interp_result_t    interp_queue[$];
    logic [DATA_W-1:0] abscissa_tbl [TABLE_DEPTH];
    logic [DATA_W-1:0] ordinate_tbl [TABLE_DEPTH];
    logic [CFG_W-1:0]  points_cfg;

    function automatic longint sx(logic [DATA_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic interp_result_t interpolate_at(logic [DATA_W-1:0] q);
        int unsigned       n;
        int unsigned       i;
        longint            xq, x0, x1, f0, f1, df, sum;
        longint unsigned   dq, den, mag, quo;
        interp_result_t    r;
        n = (points_cfg < 2) ? 2 : ((points_cfg > TABLE_DEPTH) ? TABLE_DEPTH : points_cfg);
        xq = sx(q);
        r.value = '0;
        r.out_of_range = 1'b0;
        if (xq < sx(abscissa_tbl[0]) || xq > sx(abscissa_tbl[n-1])) begin
            r.out_of_range = 1'b1;
            return r;
        end
        if (xq == sx(abscissa_tbl[0])) begin
            r.value = ordinate_tbl[0];
            return r;
        end
        i = 1;
        while (i < n - 1 && xq > sx(abscissa_tbl[i]))
            i++;
        x0 = sx(abscissa_tbl[i-1]);
        x1 = sx(abscissa_tbl[i]);
        f0 = sx(ordinate_tbl[i-1]);
        f1 = sx(ordinate_tbl[i]);
        dq = xq - x0;
        den = x1 - x0;
        df = f1 - f0;
        mag = (df < 0) ? -df : df;
        quo = (den != 0) ? (mag * dq) / den : 0;
        sum = (df < 0) ? f0 - longint'(quo) : f0 + longint'(quo);
        if (sum > longint'(SUM_MAX))
            r.value = SAT_MAX;
        else if (sum < longint'(SUM_MIN))
            r.value = SAT_MIN;
        else
            r.value = sum[DATA_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, interp_result_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%t mismatch (%s): expected value %h oor %b, got value %h oor %b",
                     $time, what, want.value, want.out_of_range, m_tdata, m_tuser);
    endtask

    always @(posedge aclk) begin
        interp_result_t want;
        logic [INDEX_W-1:0] slot;
        if (!aresetn) begin
            points_cfg = POINTS_RESET;
            interp_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                points_cfg = cfg_data;
            if (m_tvalid && m_tready) begin
                if (interp_queue.size() == 0) begin
                    want = '0;
                    flag_mismatch("result with no query outstanding", want);
                end else begin
                    want = interp_queue.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.out_of_range)
                        flag_mismatch("wrong result", want);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_LOAD) begin
                    slot = s_tdata[INDEX_W-1:0];
                    if (slot < TABLE_DEPTH) begin
                        abscissa_tbl[slot] = s_tdata[PX_LSB +: DATA_W];
                        ordinate_tbl[slot] = s_tdata[PF_LSB +: DATA_W];
                    end
                end else begin
                    interp_queue.push_back(interpolate_at(s_tdata[QX_LSB +: DATA_W]));
                end
            end
        end
        pending_results = interp_queue.size();
    end

endmodule

### tb/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables of several sizes, from two points up to the full
// depth, and fires directed and random queries at them under varying idle
// patterns on both streams; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator
    import pli_pkg::*;
();

    localparam int TABLE_DEPTH = 1024;
    localparam logic [DATA_W-1:0] X_LO = 32'h8000_0000;
    localparam logic [DATA_W-1:0] X_HI = 32'h7FFF_FFFF;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int                   mismatches;
    int                   pending_results;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    bit                   hold_request;
    int unsigned          active_points;
    logic signed [DATA_W-1:0] x_shadow [TABLE_DEPTH];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    piecewise_linear_interpolator #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    piecewise_linear_interpolator_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    task automatic send_request(logic mode, logic [INDEX_W-1:0] idx,
                                logic [DATA_W-1:0] px, logic [DATA_W-1:0] pf,
                                logic [DATA_W-1:0] qx);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[INDEX_W-1:0] = idx;
        word[INDEX_W +: DATA_W] = px;
        word[INDEX_W + DATA_W +: DATA_W] = pf;
        word[INDEX_W + 2 * DATA_W +: DATA_W] = qx;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (mode == MODE_LOAD)
            x_shadow[idx] = px;
    endtask

    task automatic load_point(int unsigned k, logic [DATA_W-1:0] px, logic [DATA_W-1:0] pf);
        send_request(MODE_LOAD, k[INDEX_W-1:0], px, pf, $urandom());
    endtask

    task automatic query_at(logic [DATA_W-1:0] q);
        send_request(MODE_QUERY, INDEX_W'($urandom_range(TABLE_DEPTH - 1)),
                     $urandom(), $urandom(), q);
    endtask

    // hold the request stream until every query has answered
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_results == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_points(logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        active_points = (v < 2) ? 2 : ((v > TABLE_DEPTH) ? TABLE_DEPTH : v);
    endtask

    task automatic fill_table(int unsigned n);
        longint lo, span;
        span = (n - 1) + $urandom_range(0, 1 << 20);
        case ($urandom_range(3))
            0: span = 64'h0_FFFF_FFFF;
            1: span = n - 1;
            2: span = (n - 1) + $urandom_range(0, 1 << 28);
            default: ;
        endcase
        lo = -64'sd2147483648 + longint'({32'b0, $urandom()} % (64'h1_0000_0000 - span));
        for (int unsigned k = 0; k < n; k++)
            load_point(k, DATA_W'(lo + (span * k) / (n - 1)), $urandom());
    endtask

    task automatic random_items(int count);
        longint          lo, hi, swap;
        longint unsigned width;
        int unsigned     k;
        int unsigned     roll;
        repeat (count) begin
            lo = x_shadow[0];
            hi = x_shadow[active_points - 1];
            if (lo > hi) begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            k = $urandom_range(active_points - 1);
            roll = $urandom_range(99);
            if (roll < 8) begin
                load_point($urandom_range(TABLE_DEPTH - 1), $urandom(), $urandom());
            end else if (roll < 58) begin
                width = hi - lo + 1;
                query_at(DATA_W'(lo + longint'({$urandom(), $urandom()} % width)));
            end else if (roll < 72) begin
                query_at(x_shadow[k]);
            end else if (roll < 82) begin
                query_at(x_shadow[k] + ($urandom_range(1) ? 1 : -1));
            end else if (roll < 87) begin
                query_at(x_shadow[0]);
            end else begin
                query_at($urandom());
            end
        end
    endtask

    task automatic run_phase(logic [CFG_W-1:0] v, bit refill, int count);
        set_points(v);
        if (refill)
            fill_table(active_points);
        random_items(count);
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_LOAD;
        tx_idle_pct   = 22;
        rx_idle_pct   = 57;
        hold_request  = 1'b0;
        active_points = 2;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load_point(0, X_LO, 32'h7FFF_FFFF);
        load_point(1, X_HI, 32'h8000_0000);
        query_at(X_LO);
        query_at(X_HI);
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
        query_at(32'h0000_0001);
        set_points(0);
        query_at(32'h1234_5678);
        // descending middle segment
        set_points(4);
        load_point(0, 32'd0, 32'd0);
        load_point(1, 32'd100, 32'd1000);
        load_point(2, 32'd50, -32'sd500);
        load_point(3, 32'd200, 32'd7);
        query_at(32'hFFFF_FFFF);
        query_at(32'd75);
        query_at(32'd150);
        query_at(32'd200);
        query_at(32'd201);
        query_at(32'd0);
        load_point(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query_at(X_LO);

        run_phase(2, 1'b1, 80);
        run_phase(CFG_W'($urandom_range(3, 16)), 1'b1, 100);
        run_phase(1, 1'b1, 40);
        run_phase(CFG_W'($urandom_range(17, 64)), 1'b1, 60);

        drain();
        tx_idle_pct = 57;
        rx_idle_pct = 22;
        run_phase(CFG_W'(TABLE_DEPTH), 1'b1, 30);
        run_phase(11'h7FF, 1'b0, 20);
        run_phase(CFG_W'($urandom_range(3, 16)), 1'b1, 80);
        run_phase(0, 1'b1, 50);

        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(CFG_W'($urandom_range(3, 32)), 1'b1, 100);
        run_phase(2, 1'b1, 50);
        set_points(CFG_W'($urandom_range(3, 16)));
        fill_table(active_points);
        hold_request = 1'b1;
        random_items(80);

        drain();
        repeat (40) @(negedge aclk);
        if (mismatches == 0 && pending_results == 0)
            $display("[piecewise_linear_interpolator] OK");
        else
            $display("[piecewise_linear_interpolator] ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[piecewise_linear_interpolator] ERROR");
        $finish;
    end

endmodule
